FILE: rtl/btt_pkg.sv
// Shared types and codes for the brace tag template tokenizer.
package btt_pkg;

    // Segment kinds
    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_VARIABLE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd1;
    localparam logic [2:0] ERR_EMPTY_TAG = 3'd2;
    localparam logic [2:0] ERR_BAD_NAME = 3'd3;
    localparam logic [2:0] ERR_TOO_LONG = 3'd4;

    // Result queue depth and the fill level up to which a new item is taken
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW = 3;
    localparam int FIFO_ACCEPT_MAX = FIFO_DEPTH - 4;

    // One result item
    typedef struct packed {
        logic [1:0] kind;
        logic [15:0] offset;
        logic [16:0] length;
        logic [2:0] err;
        logic last;
    } t_seg;

    // Up to two results produced by one input item, in order
    typedef struct packed {
        logic v0;
        logic v1;
        t_seg s0;
        t_seg s1;
    } t_push;

endpackage

FILE: rtl/btt_fifo.sv
// Result queue: takes up to two results a cycle, hands out one a cycle.
module btt_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  btt_pkg::t_push    i_push,
    input  logic              i_pop,
    output logic              o_valid,
    output btt_pkg::t_seg     o_seg,
    output logic              o_space
);

    localparam int CW = btt_pkg::FIFO_AW + 1;

    btt_pkg::t_seg r_mem [btt_pkg::FIFO_DEPTH];
    logic [btt_pkg::FIFO_AW-1:0] r_wr;
    logic [btt_pkg::FIFO_AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    logic do_pop;
    logic [1:0] n_push;
    logic [btt_pkg::FIFO_AW-1:0] wr1;

    assign do_pop = i_pop && (r_cnt != '0);
    assign n_push = {1'b0, i_push.v0} + {1'b0, i_push.v1};
    assign wr1 = r_wr + btt_pkg::FIFO_AW'(1);

    assign o_valid = (r_cnt != '0);
    assign o_seg = r_mem[r_rd];
    assign o_space = (r_cnt <= CW'(btt_pkg::FIFO_ACCEPT_MAX));

    // Store pushed results
    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr] <= i_push.s0;
        end
        if (i_push.v0 && i_push.v1) begin
            r_mem[wr1] <= i_push.s1;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            r_wr <= r_wr + btt_pkg::FIFO_AW'(n_push);
            if (do_pop) begin
                r_rd <= r_rd + btt_pkg::FIFO_AW'(1);
            end
            r_cnt <= r_cnt + CW'(n_push) - CW'(do_pop);
        end
    end

endmodule

FILE: rtl/btt_core.sv
// Tokenizer state and per-byte decision logic behind an input register.
module btt_core #(
    parameter int MAX_TEXT = 65536
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_has_byte,
    input  logic [7:0]     i_text_byte,
    input  logic           i_end_of_text,
    output btt_pkg::t_push o_push
);

    localparam int PW = $clog2(MAX_TEXT + 1);
    localparam logic [PW-1:0] MAX_POS = PW'(MAX_TEXT);
    localparam logic [7:0] CH_OPEN = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_DASH = 8'h2D;

    typedef enum logic [1:0] {
        M_LITERAL,
        M_TAG,
        M_DRAIN
    } t_mode;

    // Per-tag tracking; valid flags stand for the invalid marker
    typedef struct packed {
        logic has_content;
        logic comment;
        logic nf_v;
        logic [PW-1:0] nf;
        logic [PW-1:0] ne;
        logic bad_v;
        logic [PW-1:0] bad;
        logic bl_v;
        logic [PW-1:0] bl;
    } t_tag;

    function automatic logic is_name_byte(input logic [7:0] c);
        logic r;
        r = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_DOT || c == CH_DASH;
        return r;
    endfunction

    // Fold one content byte into the tag tracking
    function automatic t_tag content(input t_tag s, input logic [7:0] c,
                                     input logic [PW-1:0] pos);
        t_tag n;
        n = s;
        if (!s.has_content && c == CH_BANG) begin
            n.comment = 1'b1;
        end
        n.has_content = 1'b1;
        if (!n.comment) begin
            if (c == CH_SPACE || c == CH_TAB) begin
                if (s.nf_v && !s.bl_v) begin
                    n.bl_v = 1'b1;
                    n.bl = pos;
                end
            end else begin
                if (!s.nf_v) begin
                    n.nf_v = 1'b1;
                    n.nf = pos;
                end
                if (s.bl_v) begin
                    if (!s.bad_v) begin
                        n.bad_v = 1'b1;
                        n.bad = s.bl;
                    end
                    n.bl_v = 1'b0;
                end
                if (!is_name_byte(c) && !n.bad_v) begin
                    n.bad_v = 1'b1;
                    n.bad = pos;
                end
                n.ne = pos + PW'(1);
            end
        end
        return n;
    endfunction

    function automatic logic [15:0] off16(input logic [PW-1:0] v);
        logic [PW+15:0] e;
        e = {16'b0, v};
        return e[15:0];
    endfunction

    function automatic logic [16:0] len17(input logic [PW-1:0] v);
        logic [PW+16:0] e;
        e = {17'b0, v};
        return e[16:0];
    endfunction

    function automatic logic [15:0] sat16(input logic [PW-1:0] v);
        logic [PW+15:0] e;
        e = {16'b0, v};
        return (e > (PW+16)'(16'hFFFF)) ? 16'hFFFF : e[15:0];
    endfunction

    function automatic btt_pkg::t_seg mk_seg(input logic [1:0] kind, input logic [15:0] off,
                                             input logic [16:0] len, input logic [2:0] err);
        btt_pkg::t_seg s;
        s.kind = kind;
        s.offset = off;
        s.length = len;
        s.err = err;
        s.last = (kind == btt_pkg::KIND_ERROR);
        return s;
    endfunction

    // Input register
    logic r_in_valid;
    logic r_in_has;
    logic [7:0] r_in_byte;
    logic r_in_eot;

    // Parse state
    t_mode r_mode, n_mode;
    logic r_prev_open, n_prev_open;
    logic r_pend_close, n_pend_close;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_lit_base, n_lit_base;
    logic [PW-1:0] r_tag_start, n_tag_start;
    t_tag r_tag, n_tag;

    t_tag tag_mid;
    btt_pkg::t_seg a0, a1, b0;
    logic [1:0] a_cnt;
    logic b_v;
    btt_pkg::t_push push;

    always_comb begin
        n_mode = r_mode;
        n_prev_open = r_prev_open;
        n_pend_close = r_pend_close;
        n_pos = r_pos;
        n_lit_base = r_lit_base;
        n_tag_start = r_tag_start;
        n_tag = r_tag;
        tag_mid = r_tag;
        a0 = '0;
        a1 = '0;
        b0 = '0;
        a_cnt = 2'd0;
        b_v = 1'b0;
        push = '0;

        if (r_in_valid) begin
            // Take the byte
            if (r_in_has && r_mode != M_DRAIN) begin
                if (r_pos >= MAX_POS) begin
                    a0 = mk_seg(btt_pkg::KIND_ERROR, sat16(r_pos), 17'd0,
                                btt_pkg::ERR_TOO_LONG);
                    a_cnt = 2'd1;
                    n_mode = M_DRAIN;
                end else begin
                    n_pos = r_pos + PW'(1);
                    if (r_mode == M_LITERAL) begin
                        if (r_prev_open && r_in_byte == CH_OPEN) begin
                            n_prev_open = 1'b0;
                            n_tag_start = r_pos - PW'(1);
                            n_pend_close = 1'b0;
                            n_tag = '0;
                            n_mode = M_TAG;
                        end else begin
                            n_prev_open = (r_in_byte == CH_OPEN);
                        end
                    end else if (r_pend_close) begin
                        n_pend_close = 1'b0;
                        if (r_in_byte == CH_CLOSE) begin
                            // Close the tag
                            if (!r_tag.comment && !r_tag.nf_v) begin
                                a0 = mk_seg(btt_pkg::KIND_ERROR, off16(r_tag_start), 17'd0,
                                            btt_pkg::ERR_EMPTY_TAG);
                                a_cnt = 2'd1;
                                n_mode = M_DRAIN;
                            end else if (!r_tag.comment && r_tag.bad_v) begin
                                a0 = mk_seg(btt_pkg::KIND_ERROR, off16(r_tag.bad), 17'd0,
                                            btt_pkg::ERR_BAD_NAME);
                                a_cnt = 2'd1;
                                n_mode = M_DRAIN;
                            end else begin
                                if (r_tag_start > r_lit_base) begin
                                    a0 = mk_seg(btt_pkg::KIND_LITERAL, off16(r_lit_base),
                                                len17(r_tag_start - r_lit_base),
                                                btt_pkg::ERR_NONE);
                                    a_cnt = 2'd1;
                                end
                                if (!r_tag.comment) begin
                                    if (a_cnt == 2'd1) begin
                                        a1 = mk_seg(btt_pkg::KIND_VARIABLE, off16(r_tag.nf),
                                                    len17(r_tag.ne - r_tag.nf),
                                                    btt_pkg::ERR_NONE);
                                        a_cnt = 2'd2;
                                    end else begin
                                        a0 = mk_seg(btt_pkg::KIND_VARIABLE, off16(r_tag.nf),
                                                    len17(r_tag.ne - r_tag.nf),
                                                    btt_pkg::ERR_NONE);
                                        a_cnt = 2'd1;
                                    end
                                end
                                n_lit_base = r_pos + PW'(1);
                                n_mode = M_LITERAL;
                                n_tag = '0;
                            end
                        end else begin
                            // Held close brace was content after all
                            tag_mid = content(r_tag, CH_CLOSE, r_pos - PW'(1));
                            n_tag = content(tag_mid, r_in_byte, r_pos);
                        end
                    end else if (r_in_byte == CH_CLOSE) begin
                        n_pend_close = 1'b1;
                    end else begin
                        n_tag = content(r_tag, r_in_byte, r_pos);
                    end
                end
            end

            // End of text: flush trailing literal or report open tag, then restart
            if (r_in_eot) begin
                if (n_mode == M_LITERAL) begin
                    if (n_pos > n_lit_base) begin
                        b0 = mk_seg(btt_pkg::KIND_LITERAL, off16(n_lit_base),
                                    len17(n_pos - n_lit_base), btt_pkg::ERR_NONE);
                        b_v = 1'b1;
                    end
                end else if (n_mode == M_TAG) begin
                    b0 = mk_seg(btt_pkg::KIND_ERROR, off16(n_tag_start), 17'd0,
                                btt_pkg::ERR_UNTERMINATED);
                    b_v = 1'b1;
                end
                n_mode = M_LITERAL;
                n_prev_open = 1'b0;
                n_pend_close = 1'b0;
                n_pos = '0;
                n_lit_base = '0;
                n_tag_start = '0;
                n_tag = '0;
            end

            // Order results into the two slots
            unique case (a_cnt)
                2'd0: begin
                    push.v0 = b_v;
                    push.s0 = b0;
                end
                2'd1: begin
                    push.v0 = 1'b1;
                    push.s0 = a0;
                    push.v1 = b_v;
                    push.s1 = b0;
                end
                default: begin
                    push.v0 = 1'b1;
                    push.s0 = a0;
                    push.v1 = 1'b1;
                    push.s1 = a1;
                end
            endcase

            // Mark the final result of the text
            if (r_in_eot) begin
                if (push.v1) begin
                    push.s1.last = 1'b1;
                end else if (push.v0) begin
                    push.s0.last = 1'b1;
                end
            end
        end
    end

    assign o_push = push;

    // Capture accepted items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_valid;
        end
        if (i_valid) begin
            r_in_has <= i_has_byte;
            r_in_byte <= i_text_byte;
            r_in_eot <= i_end_of_text;
        end
    end

    // Hold parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_LITERAL;
            r_prev_open <= 1'b0;
            r_pend_close <= 1'b0;
            r_pos <= '0;
            r_lit_base <= '0;
            r_tag_start <= '0;
            r_tag <= '0;
        end else begin
            r_mode <= n_mode;
            r_prev_open <= n_prev_open;
            r_pend_close <= n_pend_close;
            r_pos <= n_pos;
            r_lit_base <= n_lit_base;
            r_tag_start <= n_tag_start;
            r_tag <= n_tag;
        end
    end

endmodule

FILE: rtl/brace_tag_template_tokenizer.sv
// Top level of the brace tag template tokenizer: stream ports, core and result queue.
// Takes one template byte per cycle and splits the text into literal and variable-name
// segments (offset and length), skipping comment tags and reporting the first error of
// a text. An input transfer is taken every cycle while the result queue holds four or
// fewer entries; a result appears after its byte has passed the input register and then the
// queue. A closing tag can yield a literal and a name from one byte; those leave the
// 8-entry queue one per cycle, so sustained rate is one byte per cycle as long as results
// average no more than one per byte and the sink keeps up.
module brace_tag_template_tokenizer #(
    parameter int MAX_TEXT = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_byte
    input  logic        i_s_tuser,   // [0] has_byte
    input  logic        i_s_tlast,   // end_of_text
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [15:0] seg_offset, [32:16] seg_length,
                                     // [35:33] error_code, [39:36] zero
    output logic [1:0]  o_m_tuser,   // [1:0] seg_type
    output logic        o_m_tlast    // last_segment
);

    logic s_xfer;
    logic space;
    btt_pkg::t_push push;
    btt_pkg::t_seg seg;

    assign o_s_tready = space;
    assign s_xfer = i_s_tvalid && space;

    btt_core #(
        .MAX_TEXT (MAX_TEXT)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_xfer),
        .i_has_byte    (i_s_tuser),
        .i_text_byte   (i_s_tdata),
        .i_end_of_text (i_s_tlast),
        .o_push        (push)
    );

    btt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_seg   (seg),
        .o_space (space)
    );

    // Pack the result fields
    assign o_m_tdata = {4'b0, seg.err, seg.length, seg.offset};
    assign o_m_tuser = seg.kind;
    assign o_m_tlast = seg.last;

endmodule
